/* rtl/ffrx_pkg.sv */
`default_nettype none

package ffrx_pkg;

   // frame marks
   localparam logic [7:0] START_MARK = 8'h53;   // 'S'
   localparam logic [7:0] END_MARK   = 8'h45;   // 'E'

   localparam logic [15:0] TIMEOUT_RESET = 16'd200;
   localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

   // input item kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_WORD    = 2'd0,
      STATUS_BAD_SUM = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   // sequencer steps
   typedef enum logic [1:0] {
      STEP_ACCEPT = 2'd0,
      STEP_READ   = 2'd1,
      STEP_EMIT   = 2'd2
   } step_type;

   // jump conditions
   typedef enum logic [1:0] {
      COND_NONE      = 2'd0,
      COND_GOOD_END  = 2'd1,
      COND_LAST_SENT = 2'd2
   } cond_type;

   typedef struct packed {
      logic     take_item;   // input channel open
      logic     read_word;   // read payload RAM at the word index
      logic     emit_word;   // present payload words on the output
      cond_type cond;
      step_type target;      // taken when cond holds
      step_type seq_next;    // otherwise
   } ctrl_type;

   // control store
   function automatic ctrl_type microcode(input step_type step);
      ctrl_type c;
      c = '{take_item: 1'b0, read_word: 1'b0, emit_word: 1'b0,
            cond: COND_NONE, target: STEP_ACCEPT, seq_next: STEP_ACCEPT};
      case (step)
         STEP_ACCEPT: begin
            c.take_item = 1'b1;
            c.cond      = COND_GOOD_END;
            c.target    = STEP_READ;
            c.seq_next  = STEP_ACCEPT;
         end
         STEP_READ: begin
            c.read_word = 1'b1;
            c.seq_next  = STEP_EMIT;
         end
         STEP_EMIT: begin
            c.emit_word = 1'b1;
            c.cond      = COND_LAST_SENT;
            c.target    = STEP_ACCEPT;
            c.seq_next  = STEP_EMIT;
         end
         default: begin
            c.seq_next = STEP_ACCEPT;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/fixed_frame_receiver_xor_check_unit.sv */
`default_nettype none

// channel   ports                      direction  word
// -------   -------------------------  ---------  ---------------------------------------
// req       req_valid / req_ready      in         op, rx_byte
// rsp       rsp_valid / rsp_ready      out        status, word_index, word_value,
//                                                 calc_checksum, sent_checksum, last
// csr       csr_wr_en / csr_wr_data    in         timeout_ticks, written at once
//
// A byte or a tick is taken in the accept step, one item per cycle while the
// output register drains. A good closing 'E' starts the microcoded burst: a
// read step fetches word 0 from the payload RAM, then the emit step gives one
// result per cycle out of the RAM's registered read port while rsp is not stalled.
// Reset (synchronous) restarts the frame, clears the tick count and loads a
// timeout of 200. Payload RAM is not cleared. A stalled rsp holds req off.

module fixed_frame_receiver_xor_check_unit #(
   parameter int NUM_WORDS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_op,
   input  wire logic [7:0]  req_rx_byte,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_status,
   output      logic [3:0]  rsp_word_index,
   output      logic [31:0] rsp_word_value,
   output      logic [7:0]  rsp_calc_checksum,
   output      logic [7:0]  rsp_sent_checksum,
   output      logic        rsp_last,

   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int PAYLOAD_BYTES = 4 * NUM_WORDS;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 3;
   localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   // sequencer
   ffrx_pkg::step_type step_ff, step_in;
   ffrx_pkg::ctrl_type ctrl;
   logic               cond_true;

   // frame state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       sent_ff, sent_in;
   logic [15:0]      idle_ff, idle_in;
   logic [15:0]      timeout_ff, timeout_in;
   logic [23:0]      acc_ff, acc_in;       // low bytes of the word being built
   logic [IDX_W-1:0] idx_ff, idx_in;       // burst word index

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   ffrx_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_index_ff, rsp_index_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [7:0]        rsp_calc_ff, rsp_calc_in;
   logic [7:0]        rsp_sent_ff, rsp_sent_in;
   logic              rsp_last_ff, rsp_last_in;

   // payload RAM
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [31:0]      ram_rd_data;

   logic             out_free;
   logic             take;
   logic             good_end;
   logic             is_last;
   logic [15:0]      idle_sat;
   logic [CNT_W-1:0] off;

   assign ctrl      = ffrx_pkg::microcode(step_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.take_item && out_free;
   assign take      = req_valid && req_ready;
   assign is_last   = (idx_ff == IDX_W'(NUM_WORDS - 1));
   assign idle_sat  = (idle_ff == ffrx_pkg::TICKS_MAX) ? idle_ff : idle_ff + 16'd1;
   assign off       = count_ff - CNT_W'(1);

   always_comb begin
      count_in      = count_ff;
      xor_in        = xor_ff;
      sent_in       = sent_ff;
      idle_in       = idle_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      acc_in        = acc_ff;
      idx_in        = idx_ff;
      good_end      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = IDX_W'(off >> 2);
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_calc_in   = rsp_calc_ff;
      rsp_sent_in   = rsp_sent_ff;
      rsp_last_in   = rsp_last_ff;

      if (take) begin
         if (req_op == ffrx_pkg::OP_TICK) begin
            if (idle_sat > timeout_ff) begin
               count_in      = '0;
               xor_in        = '0;
               idle_in       = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ffrx_pkg::STATUS_TIMEOUT;
               rsp_index_in  = '0;
               rsp_value_in  = '0;
               rsp_calc_in   = '0;
               rsp_sent_in   = '0;
               rsp_last_in   = 1'b1;
            end else begin
               idle_in = idle_sat;
            end
         end else if (count_ff == '0 && req_rx_byte != ffrx_pkg::START_MARK) begin
            // hunting for a start mark
         end else if (count_ff >= CNT_W'(FRAME_BYTES)) begin
            // end mark was missing: drop this byte and restart
            count_in = '0;
            xor_in   = '0;
            idle_in  = '0;
         end else begin
            count_in = count_ff + CNT_W'(1);
            if (count_ff >= CNT_W'(1) && count_ff <= CNT_W'(PAYLOAD_BYTES)) begin
               xor_in = xor_ff ^ req_rx_byte;
               acc_in = {req_rx_byte, acc_ff[23:8]};
               if (off[1:0] == 2'd3) begin
                  ram_wr_en = 1'b1;
               end
            end else if (count_ff == CNT_W'(PAYLOAD_BYTES + 1)) begin
               sent_in = req_rx_byte;
            end else if (count_ff == CNT_W'(PAYLOAD_BYTES + 2) &&
                         req_rx_byte == ffrx_pkg::END_MARK) begin
               count_in = '0;
               xor_in   = '0;
               idle_in  = '0;
               if (xor_ff == sent_ff) begin
                  good_end = 1'b1;   // burst follows from the sequencer
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ffrx_pkg::STATUS_BAD_SUM;
                  rsp_index_in  = '0;
                  rsp_value_in  = '0;
                  rsp_calc_in   = xor_ff;
                  rsp_sent_in   = sent_ff;
                  rsp_last_in   = 1'b1;
               end
            end
         end
      end

      if (ctrl.read_word) begin
         ram_rd_en = 1'b1;
      end

      // sums matched, so both checksum fields carry the received byte
      if (ctrl.emit_word && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ffrx_pkg::STATUS_WORD;
         rsp_index_in  = 4'(idx_ff);
         rsp_value_in  = ram_rd_data;
         rsp_calc_in   = sent_ff;
         rsp_sent_in   = sent_ff;
         rsp_last_in   = is_last;
         if (is_last) begin
            idx_in = '0;
         end else begin
            idx_in      = idx_ff + IDX_W'(1);
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_ff + IDX_W'(1);
         end
      end
   end

   always_comb begin
      case (ctrl.cond)
         ffrx_pkg::COND_GOOD_END:  cond_true = good_end;
         ffrx_pkg::COND_LAST_SENT: cond_true = out_free && is_last;
         default:                  cond_true = 1'b0;
      endcase
      step_in = cond_true ? ctrl.target : ctrl.seq_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ffrx_pkg::STEP_ACCEPT;
         count_ff     <= '0;
         xor_ff       <= '0;
         sent_ff      <= '0;
         idle_ff      <= '0;
         timeout_ff   <= ffrx_pkg::TIMEOUT_RESET;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         sent_ff      <= sent_in;
         idle_ff      <= idle_in;
         timeout_ff   <= timeout_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_calc_ff   <= rsp_calc_in;
      rsp_sent_ff   <= rsp_sent_in;
      rsp_last_ff   <= rsp_last_in;
   end

   ffrx_ram #(
      .WIDTH (32),
      .DEPTH (NUM_WORDS),
      .ADDR_W(IDX_W)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data({req_rx_byte, acc_ff}),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_word_index    = rsp_index_ff;
   assign rsp_word_value    = rsp_value_ff;
   assign rsp_calc_checksum = rsp_calc_ff;
   assign rsp_sent_checksum = rsp_sent_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

/* rtl/ffrx_ram.sv */
`default_nettype none

module ffrx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
